/* design/pcx_rle_pixel_decoder_assert.svh */
// assertion macros for the pcx rle pixel decoder
`ifndef PCX_RLE_PIXEL_DECODER_ASSERT_SVH
`define PCX_RLE_PIXEL_DECODER_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define PCXRLE_ASSERT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("pcx rle decoder check failed");

// next-cycle implication, disabled while reset is low
`define PCXRLE_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("pcx rle decoder check failed");

`endif

/* design/pcxrle_pkg.sv */
// ----------------------------------------------------------------------------
// pcxrle_pkg
// constants and types shared by the pcx rle pixel decoder
// ----------------------------------------------------------------------------
`default_nettype none

package pcxrle_pkg;

  localparam int unsigned MaxWidth  = 4096;
  localparam int unsigned MaxHeight = 4096;
  localparam int unsigned LineLimit = 8192;

  localparam int unsigned WidthW  = 13;  // image_width register
  localparam int unsigned LineW   = 14;  // line_bytes register
  localparam int unsigned HeightW = 13;  // image_height register
  localparam int unsigned PosW    = 13;  // position within encoded line
  localparam int unsigned RowW    = 12;
  localparam int unsigned ColW    = 12;
  localparam int unsigned RunW    = 6;
  localparam int unsigned CfgW    = 14;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [7:0]      CountMark = 8'd192;
  localparam logic [RunW-1:0] CountMask = 6'd63;

  localparam logic [WidthW-1:0]  WidthReset  = 13'd320;
  localparam logic [LineW-1:0]   LineReset   = 14'd320;
  localparam logic [HeightW-1:0] HeightReset = 13'd200;

  localparam logic [CfgIdxW-1:0] RegImageWidth  = 2'd0;
  localparam logic [CfgIdxW-1:0] RegLineBytes   = 2'd1;
  localparam logic [CfgIdxW-1:0] RegImageHeight = 2'd2;

  typedef struct packed {
    logic [7:0]      value;
    logic [ColW-1:0] column;
    logic [RowW-1:0] row;
    logic            frame_done;
  } pixel_t;

endpackage

`default_nettype wire

/* design/pcx_rle_pixel_decoder.sv */
// ----------------------------------------------------------------------------
// pcx_rle_pixel_decoder
// expands 8-bit single-plane pcx rle bytes into pixels with column and row
// ----------------------------------------------------------------------------
// Usage:
//   Compressed bytes enter on code_byte_i with in_valid_i/in_ready_o. Pixels
//   leave on the pixel_* ports with out_valid_o/out_ready_i, one transfer per
//   pixel. A byte with both top bits set is a run count for the next byte.
//   The sequencer walks one encoded line position per cycle, unless the
//   output stalls it, through a single shared position incrementer and
//   compare; padding positions are dropped. The last pixel of a byte is held
//   back one position so last_of_run can be marked, then flushed once the
//   byte's positions are walked. A run count byte, a zero-count value byte or
//   an ignored byte is taken while the decoder stays idle. A value byte for
//   n > 0 positions keeps the decoder not ready until they are walked and its
//   held pixel is flushed. Pixels pass through the hold and output registers;
//   when out_ready_i is low the output register holds its pixel and the
//   sequencer pauses on the next kept position. Reset sets width 320, line
//   bytes 320, height 200 and clears decode state. The user must write
//   configuration on cfg_we_i only while the decoder is idle; the block does
//   not enforce it. After image_height lines every byte is dropped till reset.
// ----------------------------------------------------------------------------
`default_nettype none

module pcx_rle_pixel_decoder (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           cfg_we_i,
  input  wire [pcxrle_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  wire [pcxrle_pkg::CfgW-1:0]    cfg_wdata_i,
  input  wire                           in_valid_i,
  output logic                          in_ready_o,
  input  wire [7:0]                     code_byte_i,
  output logic                          out_valid_o,
  input  wire                           out_ready_i,
  output logic [7:0]                    pixel_value_o,
  output logic [pcxrle_pkg::ColW-1:0]   pixel_column_o,
  output logic [pcxrle_pkg::RowW-1:0]   pixel_row_o,
  output logic                          last_of_run_o,
  output logic                          frame_done_o
);
  import pcxrle_pkg::*;

  `include "pcx_rle_pixel_decoder_assert.svh"

  typedef enum logic {
    StIdle,
    StRun
  } state_e;

  state_e state_q;

  logic [WidthW-1:0]  width_q;
  logic [LineW-1:0]   lbytes_q;
  logic [HeightW-1:0] height_q;

  logic            pending_q;
  logic [RunW-1:0] run_len_q;
  logic [PosW-1:0] pos_q;
  logic [RowW-1:0] row_q;
  logic            complete_q;
  logic [RunW-1:0] rep_left_q;
  logic [7:0]      value_q;

  logic   hold_valid_q;
  pixel_t hold_q;
  logic   out_valid_q;
  pixel_t out_q;
  logic   out_last_q;

  logic [WidthW-1:0]  w_eff;
  logic [LineW-1:0]   lb_eff;
  logic [HeightW-1:0] h_eff;
  logic [LineW-1:0]   kept;
  logic               produce;
  logic [PosW-1:0]    pos_inc;
  logic               line_end;
  logic [RowW-1:0]    row_inc;
  logic               row_end;
  logic               fdone;
  logic               out_free;
  logic               walking;
  logic               step_en;
  logic               in_xfer;

  // clamp registers: zero acts as one, oversize saturates
  always_comb begin
    if (width_q == '0) begin
      w_eff = WidthW'(1);
    end else if (width_q > WidthW'(MaxWidth)) begin
      w_eff = WidthW'(MaxWidth);
    end else begin
      w_eff = width_q;
    end
    if (lbytes_q == '0) begin
      lb_eff = LineW'(1);
    end else if (lbytes_q > LineW'(LineLimit)) begin
      lb_eff = LineW'(LineLimit);
    end else begin
      lb_eff = lbytes_q;
    end
    if (height_q == '0) begin
      h_eff = HeightW'(1);
    end else if (height_q > HeightW'(MaxHeight)) begin
      h_eff = HeightW'(MaxHeight);
    end else begin
      h_eff = height_q;
    end
  end

  // shared position unit: one encoded line position per cycle unless the output stalls
  always_comb begin
    kept     = (LineW'(w_eff) < lb_eff) ? LineW'(w_eff) : lb_eff;
    produce  = LineW'(pos_q) < kept;
    pos_inc  = pos_q + PosW'(1);
    line_end = (pos_inc == '0) || (LineW'(pos_inc) >= lb_eff);
    row_inc  = row_q + RowW'(1);
    row_end  = (row_inc == '0) || (HeightW'(row_inc) >= h_eff);
    fdone    = (LineW'(pos_q) == kept - LineW'(1)) &&
               (HeightW'(row_q) == h_eff - HeightW'(1));
  end

  assign out_free = !out_valid_q || out_ready_i;
  assign walking  = (state_q == StRun) && (rep_left_q != '0) && !complete_q;
  // a second kept pixel needs the output slot for the held one
  assign step_en  = walking && !(produce && hold_valid_q && !out_free);
  assign in_ready_o = (state_q == StIdle);
  assign in_xfer    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      width_q      <= WidthReset;
      lbytes_q     <= LineReset;
      height_q     <= HeightReset;
      pending_q    <= 1'b0;
      run_len_q    <= '0;
      pos_q        <= '0;
      row_q        <= '0;
      complete_q   <= 1'b0;
      rep_left_q   <= '0;
      value_q      <= '0;
      hold_valid_q <= 1'b0;
      hold_q       <= '0;
      out_valid_q  <= 1'b0;
      out_q        <= '0;
      out_last_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          RegImageWidth:  width_q  <= cfg_wdata_i[WidthW-1:0];
          RegLineBytes:   lbytes_q <= cfg_wdata_i;
          RegImageHeight: height_q <= cfg_wdata_i[HeightW-1:0];
          default: ;
        endcase
      end

      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        StIdle: begin
          if (in_xfer && !complete_q) begin
            value_q <= code_byte_i;
            if (pending_q) begin
              pending_q  <= 1'b0;
              rep_left_q <= run_len_q;
              if (run_len_q != '0) begin
                state_q <= StRun;
              end
            end else if ((code_byte_i & CountMark) == CountMark) begin
              run_len_q <= code_byte_i[RunW-1:0] & CountMask;
              pending_q <= 1'b1;
            end else begin
              rep_left_q <= RunW'(1);
              state_q    <= StRun;
            end
          end
        end
        StRun: begin
          if (walking) begin
            if (step_en) begin
              rep_left_q <= rep_left_q - RunW'(1);
              if (produce) begin
                if (hold_valid_q) begin
                  out_valid_q <= 1'b1;
                  out_q       <= hold_q;
                  out_last_q  <= 1'b0;
                end
                hold_valid_q      <= 1'b1;
                hold_q.value      <= value_q;
                hold_q.column     <= pos_q[ColW-1:0];
                hold_q.row        <= row_q;
                hold_q.frame_done <= fdone;
              end
              if (line_end) begin
                pos_q <= '0;
                row_q <= row_inc;
                if (row_end) begin
                  complete_q <= 1'b1;
                end
              end else begin
                pos_q <= pos_inc;
              end
            end
          end else begin
            // byte finished or image complete: flush the held pixel as last
            if (!hold_valid_q) begin
              state_q <= StIdle;
            end else if (out_free) begin
              out_valid_q  <= 1'b1;
              out_q        <= hold_q;
              out_last_q   <= 1'b1;
              hold_valid_q <= 1'b0;
              state_q      <= StIdle;
            end
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign out_valid_o    = out_valid_q;
  assign pixel_value_o  = out_q.value;
  assign pixel_column_o = out_q.column;
  assign pixel_row_o    = out_q.row;
  assign last_of_run_o  = out_last_q;
  assign frame_done_o   = out_q.frame_done;

  // nothing is left held back once a new byte can be taken
  `PCXRLE_ASSERT(a_idle_no_hold, clk_i, rst_ni, in_ready_o, !hold_valid_q)
  // the position unit only advances while positions remain
  `PCXRLE_ASSERT(a_step_has_work, clk_i, rst_ni, step_en, rep_left_q != '0)
  // the final pixel of the image always closes its byte
  `PCXRLE_ASSERT(a_frame_done_last, clk_i, rst_ni, out_valid_o && frame_done_o,
                 last_of_run_o)
  // bytes after the image are dropped without starting the sequencer
  `PCXRLE_ASSERT_NEXT(a_complete_drop, clk_i, rst_ni, in_xfer && complete_q,
                      state_q == StIdle)

endmodule

`default_nettype wire
